@@ rtl/sorted_key_table_top_assert.svh @@
// Assertion macros for the sorted key table top level.
// Depends on nothing; included inside the module that asserts.
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W  = 64;
  localparam int MODE_W = 2;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 11;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Shift command broadcast to every cell on the update cycle
  typedef struct packed {
    logic ins;
    logic del;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

endpackage

@@ rtl/skt_cell.sv @@
// One slot of the sorted chain: holds a key, compares it with the request
// key and shifts towards or away from its neighbours. Uses skt_pkg.
`timescale 1ns / 1ps

module skt_cell import skt_pkg::*; (
  input  logic             clk,
  input  logic             occ,
  input  logic [KEY_W-1:0] key_in,
  input  op_t              op,
  input  logic             prev_lt,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [KEY_W-1:0] next_key,
  output logic             lt,
  output logic             eq,
  output logic [KEY_W-1:0] stored_key
);

  logic [KEY_W-1:0] stored;
  logic [KEY_W-1:0] stored_next;

  assign lt         = occ && (stored < key_in);
  assign eq         = occ && (stored == key_in);
  assign stored_key = stored;

  // Slots below the insert/delete point keep their key; the rest shift.
  always_comb begin
    stored_next = stored;
    if (op.ins && !lt) begin
      stored_next = prev_lt ? key_in : prev_key;
    end else if (op.del && !lt) begin
      stored_next = next_key;
    end
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

@@ rtl/skt_first_tree.sv @@
// Registered binary tree that finds the first marked slot of the chain and
// whether that slot matched. One register level per tree level. Uses skt_pkg.
`timescale 1ns / 1ps

module skt_first_tree import skt_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic                         clk,
  input  logic [LEAVES-1:0]            mark,
  input  logic [LEAVES-1:0]            hit,
  output logic                         root_any,
  output logic                         root_hit,
  output logic [$clog2(LEAVES)-1:0]    root_idx
);

  localparam int LVL = $clog2(LEAVES);
  localparam int NP  = 1 << LVL;

  // Leaves padded to a power of two; node k has children 2k and 2k+1, and a
  // child index of NP or more is leaf (index - NP)
  logic [NP-1:0]  l_any;
  logic [NP-1:0]  l_hit;
  logic           n_any [1:NP-1];
  logic           n_hit [1:NP-1];
  logic [LVL-1:0] n_idx [1:NP-1];

  assign l_any = NP'(mark);
  assign l_hit = NP'(hit);

  for (genvar k = 1; k < NP; k++) begin : g_node
    logic           lo_any;
    logic           lo_hit;
    logic [LVL-1:0] lo_idx;
    logic           hi_any;
    logic           hi_hit;
    logic [LVL-1:0] hi_idx;

    if (2 * k >= NP) begin : g_from_leaf
      assign lo_any = l_any[2*k-NP];
      assign lo_hit = l_hit[2*k-NP];
      assign lo_idx = LVL'(2 * k - NP);
      assign hi_any = l_any[2*k+1-NP];
      assign hi_hit = l_hit[2*k+1-NP];
      assign hi_idx = LVL'(2 * k + 1 - NP);
    end else begin : g_from_node
      assign lo_any = n_any[2*k];
      assign lo_hit = n_hit[2*k];
      assign lo_idx = n_idx[2*k];
      assign hi_any = n_any[2*k+1];
      assign hi_hit = n_hit[2*k+1];
      assign hi_idx = n_idx[2*k+1];
    end

    always_ff @(posedge clk) begin
      if (lo_any) begin
        n_any[k] <= 1'b1;
        n_hit[k] <= lo_hit;
        n_idx[k] <= lo_idx;
      end else begin
        n_any[k] <= hi_any;
        n_hit[k] <= hi_hit;
        n_idx[k] <= hi_idx;
      end
    end
  end

  assign root_any = n_any[1];
  assign root_hit = n_hit[1];
  assign root_idx = n_idx[1];

endmodule

@@ rtl/sorted_key_table_top.sv @@
// Sorted key table: CAPACITY unique 64-bit keys kept in ascending order in a
// chain of cells, slots 0 .. entry_count-1.
// Input channel (in_valid/in_stall) carries mode and key: lookup, lookup or
// insert, delete (mode 3 is a lookup). Output channel (out_valid/out_stall)
// returns one item per request: found, inserted, full_reject, position and
// the count held afterwards.
// Every cell compares its key with the request key at once; a registered
// first-slot tree of log2(CAPACITY) levels then picks the position, and the
// update state (S_UPD) then shifts the chain and loads the output register.
// One item is worked on at a time; in_stall is high while it is in flight.
// A finished result sits in the output register; if out_stall holds it, the
// next item is still accepted and waits at its update cycle.
// Inserting an absent key into a full table is refused with full_reject.
// Reset (rst, synchronous) empties the table; key contents are not cleared.
// Uses skt_pkg, skt_cell and skt_first_tree.
`timescale 1ns / 1ps

module sorted_key_table_top import skt_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [KEY_W-1:0]  key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic              inserted,
  output logic              full_reject,
  output logic [POS_W-1:0]  position,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int WCW  = $clog2(PW + 1);

  state_t            state;
  logic [WCW-1:0]    wcnt;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [KEY_W-1:0]  key_q;
  logic [MODE_W-1:0] mode_q;

  logic [CAPACITY-1:0] c_lt;
  logic [CAPACITY-1:0] c_eq;
  logic [CAPACITY-1:0] c_mark;
  logic [KEY_W-1:0]    c_key [CAPACITY];

  logic          r_any;
  logic          r_hit;
  logic [PW-1:0] r_idx;

  logic accept;
  logic out_block;
  logic upd_go;
  logic hit_now;
  logic full_now;
  logic do_ins;
  logic do_del;
  logic reject;
  op_t  op;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_block = out_valid && out_stall;
  assign upd_go    = (state == S_UPD) && !out_block;

  assign hit_now  = r_any && r_hit;
  assign full_now = (count == CW'(CAPACITY));
  assign do_ins   = (mode_q == MODE_INSERT) && !hit_now && !full_now;
  assign do_del   = (mode_q == MODE_DELETE) && hit_now;
  assign reject   = (mode_q == MODE_INSERT) && !hit_now && full_now;

  assign op.ins = upd_go && do_ins;
  assign op.del = upd_go && do_del;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             p_lt;
    logic [KEY_W-1:0] p_key;
    logic [KEY_W-1:0] n_key;

    assign occ = (CW'(i) < count);
    if (i == 0) begin : g_first
      assign p_lt  = 1'b1;
      assign p_key = key_q;
    end else begin : g_mid
      assign p_lt  = c_lt[i-1];
      assign p_key = c_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign n_key = c_key[i];
    end else begin : g_inner
      assign n_key = c_key[i+1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .occ        (occ),
      .key_in     (key_q),
      .op         (op),
      .prev_lt    (p_lt),
      .prev_key   (p_key),
      .next_key   (n_key),
      .lt         (c_lt[i]),
      .eq         (c_eq[i]),
      .stored_key (c_key[i])
    );
  end

  // First slot not below the key is where it sits or goes
  assign c_mark = ~c_lt;

  skt_first_tree #(
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk      (clk),
    .mark     (c_mark),
    .hit      (c_eq),
    .root_any (r_any),
    .root_hit (r_hit),
    .root_idx (r_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcnt      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            wcnt  <= '0;
          end
        end
        S_RUN: begin
          if (wcnt == WCW'(PW - 1)) begin
            state <= S_UPD;
          end else begin
            wcnt <= wcnt + WCW'(1);
          end
        end
        S_UPD: begin
          if (upd_go) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q  <= key;
      mode_q <= mode;
    end
    if (upd_go) begin
      found       <= hit_now;
      inserted    <= do_ins;
      full_reject <= reject;
      position    <= (hit_now || do_ins) ? POS_W'(r_idx) : '0;
      entry_count <= CNT_W'(count_next);
    end
  end

  `include "sorted_key_table_top_assert.svh"

  `SKT_ASSERT_NEXT(a_ins_count, clk, rst, op.ins, count == $past(count) + CW'(1), "insert count")
  `SKT_ASSERT_NEXT(a_del_count, clk, rst, op.del, count == $past(count) - CW'(1), "delete count")
  `SKT_ASSERT_NEXT(a_upd_out, clk, rst, upd_go, out_valid && state == S_IDLE, "result not loaded")
  `SKT_ASSERT_NOW(a_one_outcome, clk, rst, out_valid, !(found && inserted) && !(found && full_reject), "outcome clash")

endmodule
